[rtl/core/ec2d_pkg.sv]
// Package for the 2-D elastic collision pipeline: beat payload types, the
// sideband carried down the stages, and shared rounding/saturation helpers.
// No dependencies.
`default_nettype none

package ec2d_pkg;

  // Unit vectors are signed Q2.28.
  localparam int unsigned UNIT_BITS = 28;
  localparam int unsigned UNIT_W    = UNIT_BITS + 2;
  // Scaled center-difference magnitudes; the larger lies in [2^30, 2^31) unless the centers coincide.
  localparam int unsigned SCL_W     = 31;
  // Length from the square root.
  localparam int unsigned LEN_W     = 32;
  // Projected velocity components.
  localparam int unsigned PROJ_W    = 34;
  // Exchanged normal components.
  localparam int unsigned FN_W      = 37;

  localparam logic signed [67:0] RND_HALF = 68'sd1 <<< (UNIT_BITS - 1);

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [15:0]        mass_a;
    logic [15:0]        mass_b;
  } ec2d_in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic               coincident;
  } ec2d_out_t;

  // Sideband that rides along with every beat.
  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic [15:0]        ma;
    logic [15:0]        mb;
    logic               neg_x;
    logic               neg_y;
    logic               coin;
  } ec2d_side_t;

  typedef struct packed {
    ec2d_side_t         side;
    logic [SCL_W-1:0]   ax;
    logic [SCL_W-1:0]   ay;
  } ec2d_geo_t;

  typedef struct packed {
    ec2d_side_t              side;
    logic signed [UNIT_W-1:0] unx;
    logic signed [UNIT_W-1:0] uny;
  } ec2d_unit_t;

  // Shift right by UNIT_BITS, round to nearest, ties away from zero.
  function automatic logic signed [39:0] rnd_sh(input logic signed [67:0] v);
    logic signed [67:0] t;
    t = v + (v[67] ? (RND_HALF - 68'sd1) : RND_HALF);
    return 40'(t >>> UNIT_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ec2d_if.sv]
// Valid/ready channel interfaces for the collision block's input and result beats.
// No dependencies.
`default_nettype none

interface ec2d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_a_x;
  logic signed [31:0] pos_a_y;
  logic signed [31:0] pos_b_x;
  logic signed [31:0] pos_b_y;
  logic signed [31:0] vel_a_x;
  logic signed [31:0] vel_a_y;
  logic signed [31:0] vel_b_x;
  logic signed [31:0] vel_b_y;
  logic [15:0]        mass_a;
  logic [15:0]        mass_b;

  modport source (output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y,
                  vel_b_x, vel_b_y, mass_a, mass_b, input ready);
  modport sink   (input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y,
                  vel_b_x, vel_b_y, mass_a, mass_b, output ready);
endinterface

interface ec2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_vel_a_x;
  logic signed [31:0] new_vel_a_y;
  logic signed [31:0] new_vel_b_x;
  logic signed [31:0] new_vel_b_y;
  logic               coincident;

  modport source (output valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
                  coincident, input ready);
  modport sink   (input valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
                  coincident, output ready);
endinterface

`default_nettype wire

[rtl/core/ec2d_norm.sv]
// Front end: center difference, magnitude scaling into [2^30, 2^31) and radicand.
// Depends on ec2d_pkg.
`default_nettype none

module ec2d_norm import ec2d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        up_valid_i,
  output logic        up_ready_o,
  input  ec2d_in_t    up_data_i,
  output logic        dn_valid_o,
  input  logic        dn_ready_i,
  output ec2d_geo_t   dn_geo_o,
  output logic [62:0] dn_rad_o
);

  localparam int NST = 5;

  typedef struct packed {
    ec2d_side_t       side;
    logic [32:0]      ax0;
    logic [32:0]      ay0;
    logic [5:0]       msb;
    logic [SCL_W-1:0] ax;
    logic [SCL_W-1:0] ay;
    logic [61:0]      sqx;
    logic [61:0]      sqy;
    logic [62:0]      rad;
  } norm_ctx_t;

  norm_ctx_t        ctx_q [NST];
  norm_ctx_t        ctx_d [NST];
  logic [NST-1:0]   v_q;
  logic [NST:0]     rdy;

  assign rdy[NST] = dn_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign up_ready_o = rdy[0];

  always_comb begin
    norm_ctx_t   c;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] mx;
    // stage 0: difference and magnitudes
    c = '0;
    dx = {up_data_i.pos_b_x[31], up_data_i.pos_b_x} - {up_data_i.pos_a_x[31], up_data_i.pos_a_x};
    dy = {up_data_i.pos_b_y[31], up_data_i.pos_b_y} - {up_data_i.pos_a_y[31], up_data_i.pos_a_y};
    c.side.vax   = up_data_i.vel_a_x;
    c.side.vay   = up_data_i.vel_a_y;
    c.side.vbx   = up_data_i.vel_b_x;
    c.side.vby   = up_data_i.vel_b_y;
    c.side.ma    = up_data_i.mass_a;
    c.side.mb    = up_data_i.mass_b;
    c.side.neg_x = dx[32];
    c.side.neg_y = dy[32];
    c.side.coin  = (dx == '0) && (dy == '0);
    c.ax0 = dx[32] ? (~dx + 33'd1) : dx;
    c.ay0 = dy[32] ? (~dy + 33'd1) : dy;
    ctx_d[0] = c;

    // stage 1: locate leading one of the larger magnitude
    c = ctx_q[0];
    mx = (c.ax0 > c.ay0) ? c.ax0 : c.ay0;
    c.msb = '0;
    for (int b = 0; b < 33; b++) begin
      if (mx[b]) c.msb = 6'(b);
    end
    ctx_d[1] = c;

    // stage 2: shift both so the larger lands in [2^30, 2^31)
    c = ctx_q[1];
    if (c.msb > 6'd30) begin
      c.ax = SCL_W'(c.ax0 >> (c.msb - 6'd30));
      c.ay = SCL_W'(c.ay0 >> (c.msb - 6'd30));
    end else begin
      c.ax = SCL_W'(c.ax0 << (6'd30 - c.msb));
      c.ay = SCL_W'(c.ay0 << (6'd30 - c.msb));
    end
    ctx_d[2] = c;

    // stage 3: squares
    c = ctx_q[2];
    c.sqx = 62'(c.ax) * 62'(c.ax);
    c.sqy = 62'(c.ay) * 62'(c.ay);
    ctx_d[3] = c;

    // stage 4: radicand
    c = ctx_q[3];
    c.rad = 63'(c.sqx) + 63'(c.sqy);
    ctx_d[4] = c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= (k == 0) ? up_valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) ctx_q[k] <= ctx_d[k];
    end
  end

  assign dn_valid_o    = v_q[NST-1];
  assign dn_geo_o.side = ctx_q[NST-1].side;
  assign dn_geo_o.ax   = ctx_q[NST-1].ax;
  assign dn_geo_o.ay   = ctx_q[NST-1].ay;
  assign dn_rad_o      = ctx_q[NST-1].rad;

  a_rad_scaled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-1] && !ctx_q[NST-1].side.coin) |-> (ctx_q[NST-1].rad[62:60] != 3'd0))
    else $error("radicand below 2^60 after scaling");

endmodule

`default_nettype wire

[rtl/core/ec2d_sqrt.sv]
// Pipelined integer square root, two result bits per stage.
// Depends on ec2d_pkg.
`default_nettype none

module ec2d_sqrt import ec2d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  ec2d_geo_t        up_geo_i,
  input  logic [62:0]      up_rad_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output ec2d_geo_t        dn_geo_o,
  output logic [LEN_W-1:0] dn_len_o
);

  localparam int NST = LEN_W / 2;

  typedef struct packed {
    ec2d_geo_t        geo;
    logic [63:0]      rem;
    logic [LEN_W-1:0] root;
  } sqrt_ctx_t;

  sqrt_ctx_t      ctx_q [NST];
  sqrt_ctx_t      ctx_d [NST];
  sqrt_ctx_t      src   [NST];
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = dn_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign up_ready_o = rdy[0];

  always_comb begin
    sqrt_ctx_t   c;
    logic [63:0] cand;
    int          bi;
    src[0].geo  = up_geo_i;
    src[0].rem  = 64'(up_rad_i);
    src[0].root = '0;
    for (int k = 1; k < NST; k++) src[k] = ctx_q[k-1];
    for (int k = 0; k < NST; k++) begin
      c = src[k];
      for (int j = 0; j < 2; j++) begin
        bi   = LEN_W - 1 - 2*k - j;
        cand = (64'(c.root) << (bi + 1)) + (64'd1 << (2*bi));
        if (c.rem >= cand) begin
          c.rem      = c.rem - cand;
          c.root[bi] = 1'b1;
        end
      end
      ctx_d[k] = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= (k == 0) ? up_valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) ctx_q[k] <= ctx_d[k];
    end
  end

  assign dn_valid_o = v_q[NST-1];
  assign dn_geo_o   = ctx_q[NST-1].geo;
  assign dn_len_o   = ctx_q[NST-1].root;

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-1] && !ctx_q[NST-1].geo.side.coin) |-> (ctx_q[NST-1].root[LEN_W-1:LEN_W-2] != 2'd0))
    else $error("length below 2^30 for a scaled difference");

endmodule

`default_nettype wire

[rtl/core/ec2d_div.sv]
// Unit normal: two pipelined restoring dividers sharing the length, then sign.
// Depends on ec2d_pkg.
`default_nettype none

module ec2d_div import ec2d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  ec2d_geo_t        up_geo_i,
  input  logic [LEN_W-1:0] up_len_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output ec2d_unit_t       dn_unit_o
);

  localparam int QB     = UNIT_W;            // quotient bits, top one always zero
  localparam int DIV_ST = QB / 2;
  localparam int NST    = DIV_ST + 1;
  localparam int RW     = UNIT_BITS + SCL_W + 2;

  typedef struct packed {
    ec2d_side_t               side;
    logic [LEN_W-1:0]         len;
    logic [RW-1:0]            rx;
    logic [RW-1:0]            ry;
    logic [QB-1:0]            qx;
    logic [QB-1:0]            qy;
    logic signed [UNIT_W-1:0] unx;
    logic signed [UNIT_W-1:0] uny;
  } div_ctx_t;

  div_ctx_t       ctx_q [NST];
  div_ctx_t       ctx_d [NST];
  div_ctx_t       src   [NST];
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = dn_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign up_ready_o = rdy[0];

  always_comb begin
    div_ctx_t      c;
    logic [RW-1:0] dv;
    int            bi;
    src[0]      = '0;
    src[0].side = up_geo_i.side;
    src[0].len  = up_len_i;
    src[0].rx   = (RW'(up_geo_i.ax) << UNIT_BITS) + RW'(up_len_i >> 1);
    src[0].ry   = (RW'(up_geo_i.ay) << UNIT_BITS) + RW'(up_len_i >> 1);
    for (int k = 1; k < NST; k++) src[k] = ctx_q[k-1];
    for (int k = 0; k < NST; k++) begin
      c = src[k];
      if (k < DIV_ST) begin
        for (int j = 0; j < 2; j++) begin
          bi = QB - 1 - 2*k - j;
          dv = RW'(c.len) << bi;
          if (c.rx >= dv) begin
            c.rx     = c.rx - dv;
            c.qx[bi] = 1'b1;
          end
          if (c.ry >= dv) begin
            c.ry     = c.ry - dv;
            c.qy[bi] = 1'b1;
          end
        end
      end else begin
        // apply the sign of the difference
        c.unx = c.side.neg_x ? -$signed(c.qx) : $signed(c.qx);
        c.uny = c.side.neg_y ? -$signed(c.qy) : $signed(c.qy);
      end
      ctx_d[k] = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= (k == 0) ? up_valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) ctx_q[k] <= ctx_d[k];
    end
  end

  assign dn_valid_o     = v_q[NST-1];
  assign dn_unit_o.side = ctx_q[NST-1].side;
  assign dn_unit_o.unx  = ctx_q[NST-1].unx;
  assign dn_unit_o.uny  = ctx_q[NST-1].uny;

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NST-1] && !ctx_q[NST-1].side.coin) |->
      ((ctx_q[NST-1].unx <= 30'sd268435456) && (ctx_q[NST-1].unx >= -30'sd268435456) &&
       (ctx_q[NST-1].uny <= 30'sd268435456) && (ctx_q[NST-1].uny >= -30'sd268435456)))
    else $error("unit normal component exceeds one");

endmodule

`default_nettype wire

[rtl/core/ec2d_resp.sv]
// Response: projections, 1-D elastic exchange with a pipelined divider,
// rebuild of both velocity vectors, rounding and saturation.
// Depends on ec2d_pkg.
`default_nettype none

module ec2d_resp import ec2d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       up_valid_i,
  output logic       up_ready_o,
  input  ec2d_unit_t up_unit_i,
  output logic       dn_valid_o,
  input  logic       dn_ready_i,
  output ec2d_out_t  dn_data_o
);

  localparam int QB      = 36;
  localparam int DIV_ST  = QB / 2;
  localparam int RW      = 53;
  localparam int ST_DIV0 = 6;
  localparam int ST_FN   = ST_DIV0 + DIV_ST;
  localparam int ST_RP   = ST_FN + 1;
  localparam int ST_RS   = ST_FN + 2;
  localparam int ST_OUT  = ST_FN + 3;
  localparam int NST     = ST_OUT + 1;

  typedef struct packed {
    ec2d_side_t               side;
    logic signed [UNIT_W-1:0] unx;
    logic signed [UNIT_W-1:0] uny;
    logic signed [61:0]       p0, p1, p2, p3, p4, p5, p6, p7;
    logic signed [62:0]       n1, t1, n2, t2;
    logic signed [PROJ_W-1:0] s1n, s1t, s2n, s2t;
    logic signed [16:0]       dm;
    logic [16:0]              msum;
    logic signed [52:0]       e1, e2, e3, e4;
    logic signed [53:0]       num1, num2;
    logic                     neg1, neg2;
    logic [RW-1:0]            r1, r2;
    logic [QB-1:0]            q1, q2;
    logic signed [FN_W-1:0]   f1, f2;
    logic signed [66:0]       g0, g1, g2, g3, g4, g5, g6, g7;
    logic signed [67:0]       h0, h1, h2, h3;
    ec2d_out_t                res;
  } resp_ctx_t;

  resp_ctx_t      ctx_q [NST];
  resp_ctx_t      ctx_d [NST];
  resp_ctx_t      src   [NST];
  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  assign rdy[NST] = dn_ready_i;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign up_ready_o = rdy[0];

  always_comb begin
    resp_ctx_t     c;
    logic [RW-1:0] dv;
    int            bi;
    src[0]      = '0;
    src[0].side = up_unit_i.side;
    src[0].unx  = up_unit_i.unx;
    src[0].uny  = up_unit_i.uny;
    for (int k = 1; k < NST; k++) src[k] = ctx_q[k-1];
    for (int k = 0; k < NST; k++) begin
      c = src[k];
      if (k == 0) begin
        // projection products
        c.p0 = $signed(c.unx) * $signed(c.side.vax);
        c.p1 = $signed(c.uny) * $signed(c.side.vay);
        c.p2 = $signed(c.unx) * $signed(c.side.vay);
        c.p3 = $signed(c.uny) * $signed(c.side.vax);
        c.p4 = $signed(c.unx) * $signed(c.side.vbx);
        c.p5 = $signed(c.uny) * $signed(c.side.vby);
        c.p6 = $signed(c.unx) * $signed(c.side.vby);
        c.p7 = $signed(c.uny) * $signed(c.side.vbx);
      end else if (k == 1) begin
        c.n1 = $signed(c.p0) + $signed(c.p1);
        c.t1 = $signed(c.p2) - $signed(c.p3);
        c.n2 = $signed(c.p4) + $signed(c.p5);
        c.t2 = $signed(c.p6) - $signed(c.p7);
      end else if (k == 2) begin
        c.s1n  = PROJ_W'(rnd_sh(68'($signed(c.n1))));
        c.s1t  = PROJ_W'(rnd_sh(68'($signed(c.t1))));
        c.s2n  = PROJ_W'(rnd_sh(68'($signed(c.n2))));
        c.s2t  = PROJ_W'(rnd_sh(68'($signed(c.t2))));
        c.dm   = $signed({1'b0, c.side.ma}) - $signed({1'b0, c.side.mb});
        c.msum = {1'b0, c.side.ma} + {1'b0, c.side.mb};
      end else if (k == 3) begin
        c.e1 = $signed(c.s1n) * $signed(c.dm);
        c.e2 = $signed({1'b0, c.side.mb, 1'b0}) * $signed(c.s2n);
        c.e3 = $signed(c.s2n) * $signed(c.dm);
        c.e4 = $signed({1'b0, c.side.ma, 1'b0}) * $signed(c.s1n);
      end else if (k == 4) begin
        c.num1 = $signed(c.e1) + $signed(c.e2);
        c.num2 = $signed(c.e4) - $signed(c.e3);
      end else if (k == 5) begin
        // magnitude plus half the divisor
        c.neg1 = c.num1[53];
        c.neg2 = c.num2[53];
        c.r1 = RW'(c.neg1 ? (~c.num1 + 54'd1) : c.num1) + RW'(c.msum >> 1);
        c.r2 = RW'(c.neg2 ? (~c.num2 + 54'd1) : c.num2) + RW'(c.msum >> 1);
        c.q1 = '0;
        c.q2 = '0;
      end else if (k < ST_FN) begin
        for (int j = 0; j < 2; j++) begin
          bi = QB - 1 - 2*(k - ST_DIV0) - j;
          dv = RW'(c.msum) << bi;
          if (c.r1 >= dv) begin
            c.r1     = c.r1 - dv;
            c.q1[bi] = 1'b1;
          end
          if (c.r2 >= dv) begin
            c.r2     = c.r2 - dv;
            c.q2[bi] = 1'b1;
          end
        end
      end else if (k == ST_FN) begin
        // both masses zero: swap the normal parts
        if (c.msum == '0) begin
          c.f1 = FN_W'(c.s2n);
          c.f2 = FN_W'(c.s1n);
        end else begin
          c.f1 = c.neg1 ? -$signed({1'b0, c.q1}) : $signed({1'b0, c.q1});
          c.f2 = c.neg2 ? -$signed({1'b0, c.q2}) : $signed({1'b0, c.q2});
        end
      end else if (k == ST_RP) begin
        c.g0 = $signed(c.unx) * $signed(c.f1);
        c.g1 = $signed(c.uny) * $signed(c.s1t);
        c.g2 = $signed(c.uny) * $signed(c.f1);
        c.g3 = $signed(c.unx) * $signed(c.s1t);
        c.g4 = $signed(c.unx) * $signed(c.f2);
        c.g5 = $signed(c.uny) * $signed(c.s2t);
        c.g6 = $signed(c.uny) * $signed(c.f2);
        c.g7 = $signed(c.unx) * $signed(c.s2t);
      end else if (k == ST_RS) begin
        c.h0 = $signed(c.g0) - $signed(c.g1);
        c.h1 = $signed(c.g2) + $signed(c.g3);
        c.h2 = $signed(c.g4) - $signed(c.g5);
        c.h3 = $signed(c.g6) + $signed(c.g7);
      end else begin
        // coincident centers pass the velocities through
        c.res.coincident = c.side.coin;
        if (c.side.coin) begin
          c.res.new_vel_a_x = c.side.vax;
          c.res.new_vel_a_y = c.side.vay;
          c.res.new_vel_b_x = c.side.vbx;
          c.res.new_vel_b_y = c.side.vby;
        end else begin
          c.res.new_vel_a_x = sat32(rnd_sh(c.h0));
          c.res.new_vel_a_y = sat32(rnd_sh(c.h1));
          c.res.new_vel_b_x = sat32(rnd_sh(c.h2));
          c.res.new_vel_b_y = sat32(rnd_sh(c.h3));
        end
      end
      ctx_d[k] = c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) v_q[k] <= (k == 0) ? up_valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) ctx_q[k] <= ctx_d[k];
    end
  end

  assign dn_valid_o = v_q[NST-1];
  assign dn_data_o  = ctx_q[NST-1].res;

endmodule

`default_nettype wire

[rtl/core/elastic_collision_2d_top.sv]
// Top level of the 2-D elastic collision response pipeline.
// Depends on ec2d_pkg, ec2d_if, ec2d_norm, ec2d_sqrt, ec2d_div, ec2d_resp.
`default_nettype none

// Each input beat carries the centers, velocities (signed Q16.16) and masses
// (unsigned Q8.8) of two bodies; each result beat carries both velocities after
// an elastic collision along the line of centers, saturated to 32 bits, plus a
// coincident flag (centers equal: velocities pass through unchanged). The block
// takes one beat every cycle while the input is not back-pressured and passes it
// through its stages to the result register: scaling and the radicand, the
// square root (two root bits per stage), the unit-normal dividers (two quotient
// bits per stage plus sign), then projection, the mass-exchange divider (18
// stages of two bits) and the rebuild. Every stage has its own valid bit and
// loads whenever it is empty or its successor moves, so a stall on the result
// side fills bubbles first and back-pressure reaches the input only when all 65
// stages hold beats. Nothing is lost or repeated across a stall.
module elastic_collision_2d_top import ec2d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ec2d_in_if.sink     in_i,
  ec2d_out_if.source  out_o
);

  ec2d_in_t         in_data;
  ec2d_out_t        out_data;

  logic             nrm_valid, nrm_ready;
  ec2d_geo_t        nrm_geo;
  logic [62:0]      nrm_rad;

  logic             sq_valid, sq_ready;
  ec2d_geo_t        sq_geo;
  logic [LEN_W-1:0] sq_len;

  logic             dv_valid, dv_ready;
  ec2d_unit_t       dv_unit;

  // Gather the input beat into one payload word.
  assign in_data.pos_a_x = in_i.pos_a_x;
  assign in_data.pos_a_y = in_i.pos_a_y;
  assign in_data.pos_b_x = in_i.pos_b_x;
  assign in_data.pos_b_y = in_i.pos_b_y;
  assign in_data.vel_a_x = in_i.vel_a_x;
  assign in_data.vel_a_y = in_i.vel_a_y;
  assign in_data.vel_b_x = in_i.vel_b_x;
  assign in_data.vel_b_y = in_i.vel_b_y;
  assign in_data.mass_a  = in_i.mass_a;
  assign in_data.mass_b  = in_i.mass_b;

  // Scale the center difference and form the squared length.
  ec2d_norm u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_i.valid),
    .up_ready_o (in_i.ready),
    .up_data_i  (in_data),
    .dn_valid_o (nrm_valid),
    .dn_ready_i (nrm_ready),
    .dn_geo_o   (nrm_geo),
    .dn_rad_o   (nrm_rad)
  );

  // Length of the scaled difference.
  ec2d_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (nrm_valid),
    .up_ready_o (nrm_ready),
    .up_geo_i   (nrm_geo),
    .up_rad_i   (nrm_rad),
    .dn_valid_o (sq_valid),
    .dn_ready_i (sq_ready),
    .dn_geo_o   (sq_geo),
    .dn_len_o   (sq_len)
  );

  // Unit normal in Q2.28.
  ec2d_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (sq_valid),
    .up_ready_o (sq_ready),
    .up_geo_i   (sq_geo),
    .up_len_i   (sq_len),
    .dn_valid_o (dv_valid),
    .dn_ready_i (dv_ready),
    .dn_unit_o  (dv_unit)
  );

  // Project, exchange along the normal, rebuild and saturate.
  ec2d_resp u_resp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (dv_valid),
    .up_ready_o (dv_ready),
    .up_unit_i  (dv_unit),
    .dn_valid_o (out_o.valid),
    .dn_ready_i (out_o.ready),
    .dn_data_o  (out_data)
  );

  // Spread the result word onto the result channel.
  assign out_o.new_vel_a_x = out_data.new_vel_a_x;
  assign out_o.new_vel_a_y = out_data.new_vel_a_y;
  assign out_o.new_vel_b_x = out_data.new_vel_b_x;
  assign out_o.new_vel_b_y = out_data.new_vel_b_y;
  assign out_o.coincident  = out_data.coincident;

  // Back-pressure at the input only arises from a full, stalled pipeline.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled while the result side is free");

endmodule

`default_nettype wire

[verif/ec2d_tb_pkg.sv]
// Test-side types for the collision testbench: the stimulus row with an optional expected result.
// Depends on ec2d_pkg.
`default_nettype none

package ec2d_tb_pkg;
  import ec2d_pkg::*;

  typedef struct {
    ec2d_in_t  beat;
    bit        has_gold;
    ec2d_out_t gold;
  } stim_row_t;
endpackage

`default_nettype wire

[verif/testbench.sv]
// Testbench for elastic_collision_2d_top: a directed table and random beats,
// each result checked against a typed-in expected value or an in-bench collision predictor.
// Depends on ec2d_pkg, ec2d_tb_pkg, ec2d_if and the RTL of the block.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ec2d_pkg::*;
  import ec2d_tb_pkg::*;

  localparam int LATENCY   = 65;
  localparam int IDLE_MAX  = 12;
  localparam int RAND_ITEMS = 430;
  localparam int STALL_LEN = 200;
  localparam int WDOG_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ec2d_in_if  in_ch();
  ec2d_out_if out_ch();

  elastic_collision_2d_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Pending results, oldest first.
  ec2d_out_t vel_queue[$];
  int        n_errors = 0;
  bit        src_done = 1'b0;
  bit        long_stall = 1'b0;
  int        quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Collision predictor
  // ---------------------------------------------------------------------------
  function automatic longint rnd_unit(longint v);
    longint unsigned m;
    m = ((v < 0) ? -v : v) + (64'd1 << 27);
    m = m >> 28;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_near(longint num, longint unsigned den);
    longint unsigned m;
    m = (((num < 0) ? -num : num) + den / 2) / den;
    return (num < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic ec2d_out_t collide(ec2d_in_t b);
    ec2d_out_t r;
    longint dx, dy, vax, vay, vbx, vby, ma, mb;
    longint unsigned ax, ay, mx, len, msum;
    longint unx, uny, s1n, s1t, s2n, s2t, f1n, f2n, dm;
    dx = longint'(b.pos_b_x) - longint'(b.pos_a_x);
    dy = longint'(b.pos_b_y) - longint'(b.pos_a_y);
    vax = longint'(b.vel_a_x); vay = longint'(b.vel_a_y);
    vbx = longint'(b.vel_b_x); vby = longint'(b.vel_b_y);
    ma = longint'(b.mass_a); mb = longint'(b.mass_b);
    if (dx == 0 && dy == 0) begin
      r.new_vel_a_x = b.vel_a_x; r.new_vel_a_y = b.vel_a_y;
      r.new_vel_b_x = b.vel_b_x; r.new_vel_b_y = b.vel_b_y;
      r.coincident = 1'b1;
      return r;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    mx = (ax > ay) ? ax : ay;
    // normalize the larger magnitude into [2^30, 2^31)
    while (mx >= (64'd1 << 31)) begin
      ax = ax >> 1; ay = ay >> 1; mx = mx >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      ax = ax << 1; ay = ay << 1; mx = mx << 1;
    end
    len = root_floor(ax * ax + ay * ay);
    unx = ((ax << 28) + len / 2) / len;
    uny = ((ay << 28) + len / 2) / len;
    if (dx < 0) unx = -unx;
    if (dy < 0) uny = -uny;
    s1n = rnd_unit(unx * vax + uny * vay);
    s1t = rnd_unit(unx * vay - uny * vax);
    s2n = rnd_unit(unx * vbx + uny * vby);
    s2t = rnd_unit(unx * vby - uny * vbx);
    msum = ma + mb;
    dm = ma - mb;
    if (msum == 0) begin
      // both masses zero: swap the normal parts
      f1n = s2n;
      f2n = s1n;
    end else begin
      f1n = div_near(s1n * dm + 2 * mb * s2n, msum);
      f2n = div_near(-(s2n * dm) + 2 * ma * s1n, msum);
    end
    r.new_vel_a_x = clamp32(rnd_unit(unx * f1n - uny * s1t));
    r.new_vel_a_y = clamp32(rnd_unit(uny * f1n + unx * s1t));
    r.new_vel_b_x = clamp32(rnd_unit(unx * f2n - uny * s2t));
    r.new_vel_b_y = clamp32(rnd_unit(uny * f2n + unx * s2t));
    r.coincident = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] PMIN = 32'sh80000000;

  function automatic ec2d_in_t mk(logic signed [31:0] pax, pay, pbx, pby,
                                  vax, vay, vbx, vby, logic [15:0] ma, mb);
    ec2d_in_t b;
    b.pos_a_x = pax; b.pos_a_y = pay; b.pos_b_x = pbx; b.pos_b_y = pby;
    b.vel_a_x = vax; b.vel_a_y = vay; b.vel_b_x = vbx; b.vel_b_y = vby;
    b.mass_a = ma; b.mass_b = mb;
    return b;
  endfunction

  function automatic ec2d_out_t mko(logic signed [31:0] a, b, c, d, logic coin);
    ec2d_out_t o;
    o.new_vel_a_x = a; o.new_vel_a_y = b; o.new_vel_b_x = c; o.new_vel_b_y = d;
    o.coincident = coin;
    return o;
  endfunction

  stim_row_t dir_rows[$];

  task automatic add_row(ec2d_in_t b, bit has, ec2d_out_t g);
    stim_row_t s;
    s.beat = b; s.has_gold = has; s.gold = g;
    dir_rows.push_back(s);
  endtask

  task automatic build_table();
    ec2d_out_t none;
    none = '0;
    // coincident centers: velocities pass through, extremes included
    add_row(mk(0, 0, 0, 0, PMAX, PMIN, -1, 1, 16'hFFFF, 1), 1,
            mko(PMAX, PMIN, -1, 1, 1'b1));
    add_row(mk(PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMAX, PMIN, 1, 16'hFFFF), 1,
            mko(PMIN, PMAX, PMAX, PMIN, 1'b1));
    // equal masses head on along x: normal parts swap exactly
    add_row(mk(0, 0, 32'sh10000, 0, 32'sh10000, 0, -32'sh10000, 0, 256, 256), 1,
            mko(-32'sh10000, 0, 32'sh10000, 0, 1'b0));
    // along y, equal masses
    add_row(mk(0, 0, 0, 32'sh20000, 0, 32'sh30000, 0, 0, 256, 256), 1,
            mko(0, 0, 0, 32'sh30000, 1'b0));
    // widest separations (33-bit difference), extreme velocities, saturation
    add_row(mk(PMIN, PMIN, PMAX, PMAX, PMAX, PMAX, PMIN, PMIN, 16'hFFFF, 16'hFFFF),
            0, none);
    add_row(mk(PMAX, PMAX, PMIN, PMIN, PMAX, PMIN, PMIN, PMAX, 1, 16'hFFFF), 0, none);
    add_row(mk(PMAX, 0, PMIN, 0, PMIN, PMIN, PMAX, PMAX, 16'hFFFF, 1), 0, none);
    add_row(mk(0, PMIN, 0, PMAX, PMAX, PMAX, PMAX, PMAX, 16'hFFFF, 1), 0, none);
    // tiny separations, heavy scaling up
    add_row(mk(0, 0, 1, 0, 32'sh1234, -32'sh777, 5, 9, 1, 1), 0, none);
    add_row(mk(5, 5, 4, 6, -100, 200, 300, -400, 3, 700), 0, none);
    add_row(mk(0, 0, -1, -1, PMIN, 0, 0, PMIN, 16'h8000, 16'h0100), 0, none);
    // diagonal and axis-aligned separations, mostly unequal masses
    add_row(mk(-32'sh30000, 32'sh40000, 32'sh50000, -32'sh10000,
               32'sh18000, -32'sh4000, -32'sh22000, 32'sh9000, 100, 9000), 0, none);
    add_row(mk(0, 0, 3, 4, 32'sh50000, 0, 0, 0, 16'hFFFF, 16'hFFFF), 0, none);
    add_row(mk(0, 0, -3, 4, 0, -32'sh50000, 32'sh7000, 1, 1, 2), 0, none);
    add_row(mk(1, 1, 1, 2, -1, -1, -1, -1, 16'h00FF, 16'hFF00), 0, none);
  endtask

  function automatic logic signed [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000FFFFF)) - 32'sh80000;
      2: return $urandom_range(0, 3) == 0 ? PMAX : ($urandom_range(0, 1) ? PMIN : 0);
      default: return $signed($urandom_range(0, 32'h3FF)) - 32'sh200;
    endcase
  endfunction

  function automatic ec2d_in_t rand_beat();
    ec2d_in_t b;
    int pm, vm;
    pm = $urandom_range(0, 3);
    vm = $urandom_range(0, 2);
    b.pos_a_x = rand_word(pm); b.pos_a_y = rand_word(pm);
    b.pos_b_x = rand_word(pm); b.pos_b_y = rand_word(pm);
    // occasionally make the centers meet
    if ($urandom_range(0, 19) == 0) begin
      b.pos_b_x = b.pos_a_x; b.pos_b_y = b.pos_a_y;
    end
    b.vel_a_x = rand_word(vm); b.vel_a_y = rand_word(vm);
    b.vel_b_x = rand_word(vm); b.vel_b_y = rand_word(vm);
    b.mass_a = 16'($urandom_range(1, 16'hFFFF));
    b.mass_b = ($urandom_range(0, 3) == 0) ? b.mass_a : 16'($urandom_range(1, 16'hFFFF));
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: drive a beat, hold until accepted, draw a gap before the next
  // ---------------------------------------------------------------------------
  task automatic send_beat(ec2d_in_t b, bit has, ec2d_out_t g, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, IDLE_MAX);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pos_a_x <= b.pos_a_x; in_ch.pos_a_y <= b.pos_a_y;
    in_ch.pos_b_x <= b.pos_b_x; in_ch.pos_b_y <= b.pos_b_y;
    in_ch.vel_a_x <= b.vel_a_x; in_ch.vel_a_y <= b.vel_a_y;
    in_ch.vel_b_x <= b.vel_b_x; in_ch.vel_b_y <= b.vel_b_y;
    in_ch.mass_a  <= b.mass_a;  in_ch.mass_b  <= b.mass_b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    // accepted on this edge: queue the prediction, typed-in value takes priority
    vel_queue.push_back(has ? g : collide(b));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_a_x = '0; in_ch.pos_a_y = '0; in_ch.pos_b_x = '0; in_ch.pos_b_y = '0;
    in_ch.vel_a_x = '0; in_ch.vel_a_y = '0; in_ch.vel_b_x = '0; in_ch.vel_b_y = '0;
    in_ch.mass_a = 16'd1; in_ch.mass_b = 16'd1;
    build_table();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].has_gold,
                                    dir_rows[i].gold, 1'b0);
    for (int k = 0; k < RAND_ITEMS; k++) begin
      // back-to-back burst into a held-off receiver to fill the pipeline
      if (k == 60) long_stall = 1'b1;
      if (k >= 60 && k < 160) begin
        send_beat(rand_beat(), 1'b0, '0, 1'b1);
      end else if (k >= 200 && k < 260) begin
        // stretch with no idling on the input side
        send_beat(rand_beat(), 1'b0, '0, 1'b1);
      end else begin
        send_beat(rand_beat(), 1'b0, '0, 1'b0);
      end
      // drain completely once mid-run
      if (k == 300) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while (vel_queue.size() != 0) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;
    src_done = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, one long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_stall) begin
        long_stall = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk_i);
      end
      wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    ec2d_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (vel_queue.size() == 0) begin
        report_mismatch("result beat without prediction", 1, 0);
      end else begin
        want = vel_queue.pop_front();
        if (out_ch.new_vel_a_x !== want.new_vel_a_x)
          report_mismatch("new_vel_a_x", out_ch.new_vel_a_x, want.new_vel_a_x);
        if (out_ch.new_vel_a_y !== want.new_vel_a_y)
          report_mismatch("new_vel_a_y", out_ch.new_vel_a_y, want.new_vel_a_y);
        if (out_ch.new_vel_b_x !== want.new_vel_b_x)
          report_mismatch("new_vel_b_x", out_ch.new_vel_b_x, want.new_vel_b_x);
        if (out_ch.new_vel_b_y !== want.new_vel_b_y)
          report_mismatch("new_vel_b_y", out_ch.new_vel_b_y, want.new_vel_b_y);
        if (out_ch.coincident !== want.coincident)
          report_mismatch("coincident", out_ch.coincident, want.coincident);
      end
    end
  end

  // Watchdog: count cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // End of run: drain, then let the pipeline settle before the verdict.
  initial begin
    wait (src_done);
    while (vel_queue.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (n_errors == 0 && vel_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
